>>> rtl/gpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared constants, types and helper functions of the grid pattern pixel
// generator: field widths, register indexes, clamps and the remainder step.
// ----------------------------------------------------------------------------
package gpg_pkg;

  // Largest image size and cell count the datapath is sized for.
  localparam int MAX_DIM   = 4096;
  localparam int MAX_CELLS = 256;

  // Interface field widths.
  localparam int COORD_W    = 12;
  localparam int DIM_CFG_W  = 13;
  localparam int CELL_CFG_W = 9;
  localparam int THICK_W    = 16;
  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Datapath widths.
  localparam int D_W        = $clog2(MAX_DIM);          // divisor, dim - 1
  localparam int C_W        = $clog2(MAX_CELLS + 1);    // clamped cell count
  localparam int P_W        = COORD_W + C_W;            // coordinate * cells
  localparam int DIV_STAGES = 3;
  localparam int DIV_BITS   = (P_W + DIV_STAGES - 1) / DIV_STAGES;
  localparam int PAD_W      = DIV_STAGES * DIV_BITS;
  localparam int L_W        = THICK_W + D_W;            // thickness * divisor
  localparam int NUM_STAGES = DIV_STAGES + 2;           // multiply, divide, output

  // Register reset values.
  localparam logic [DIM_CFG_W-1:0]  RST_IMAGE_WIDTH    = 13'd256;
  localparam logic [DIM_CFG_W-1:0]  RST_IMAGE_HEIGHT   = 13'd256;
  localparam logic [CELL_CFG_W-1:0] RST_CELL_COLUMNS   = 9'd8;
  localparam logic [CELL_CFG_W-1:0] RST_CELL_ROWS      = 9'd8;
  localparam logic [THICK_W-1:0]    RST_LINE_THICKNESS = 16'd3277;
  localparam logic [COLOR_W-1:0]    RST_FILL_COLOR     = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0]    RST_GRID_COLOR     = 24'h000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_CELL_COLUMNS   = 3'd2,
    REG_CELL_ROWS      = 3'd3,
    REG_LINE_THICKNESS = 3'd4,
    REG_FILL_COLOR     = 3'd5,
    REG_GRID_COLOR     = 3'd6
  } cfg_reg_t;

  // Per-axis settings, already clamped.
  typedef struct packed {
    logic [D_W-1:0]     d;
    logic [C_W-1:0]     cells;
    logic [THICK_W-1:0] thick;
  } axis_cfg_t;

  // Clamp an image size to [2, MAX_DIM] and return size - 1.
  function automatic logic [D_W-1:0] clamp_div(logic [DIM_CFG_W-1:0] v);
    logic [D_W-1:0] res;
    if (v < DIM_CFG_W'(2)) begin
      res = D_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      res = D_W'(MAX_DIM - 1);
    end else begin
      res = D_W'(v - DIM_CFG_W'(1));
    end
    return res;
  endfunction

  // Clamp a cell count to [1, MAX_CELLS].
  function automatic logic [C_W-1:0] clamp_cells(logic [CELL_CFG_W-1:0] v);
    logic [C_W-1:0] res;
    if (v == '0) begin
      res = C_W'(1);
    end else if (32'(v) > 32'(MAX_CELLS)) begin
      res = C_W'(MAX_CELLS);
    end else begin
      res = C_W'(v);
    end
    return res;
  endfunction

  // Restoring remainder over DIV_BITS dividend bits, most significant first.
  // rem must already be below d.
  function automatic logic [D_W-1:0] div_step(logic [D_W-1:0]      rem,
                                              logic [DIV_BITS-1:0] bits,
                                              logic [D_W-1:0]      d);
    logic [D_W:0]   acc;
    logic [D_W-1:0] r;
    r = rem;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= {1'b0, d}) begin
        acc = acc - {1'b0, d};
      end
      r = acc[D_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/gpg_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_axis
// One axis of the grid test: position * cells, remainder by (dim - 1) over
// a pipelined restoring divider, then the edge distance test against the
// line thickness.
// ----------------------------------------------------------------------------
module gpg_axis import gpg_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES:0]   load,
  input  logic [COORD_W-1:0]    pos,
  input  axis_cfg_t             cfg,
  output logic                  near
);

  logic [P_W-1:0]   prod;
  logic [PAD_W-1:0] prod_q [DIV_STAGES];
  logic [D_W-1:0]   rem_q  [DIV_STAGES];
  logic [L_W-1:0]   lim_q;
  logic [D_W-1:0]   rem_f;
  logic [D_W-1:0]   rem_c;

  assign prod = pos * cfg.cells;

  // User changes settings only when idle (unenforced). lim_q loads each cycle.
  always_ff @(posedge clk) begin
    lim_q <= cfg.thick * cfg.d;
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      prod_q[0] <= PAD_W'(prod);
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [D_W-1:0] rem_in;
    if (k == 0) begin : g_first
      assign rem_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (load[k+1]) begin
        rem_q[k] <= div_step(rem_in, prod_q[k][PAD_W-1-k*DIV_BITS -: DIV_BITS], cfg.d);
      end
    end

    if (k < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (load[k+1]) begin
          prod_q[k+1] <= prod_q[k];
        end
      end
    end
  end

  // Distance to the low edge is rem, to the high edge d - rem (never zero).
  assign rem_f = rem_q[DIV_STAGES-1];
  assign rem_c = cfg.d - rem_f;
  assign near  = ({rem_f, {THICK_W{1'b0}}} < lim_q) ||
                 ({rem_c, {THICK_W{1'b0}}} < lim_q);

endmodule

>>> rtl/grid_pattern_pixel_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_pattern_pixel_generator
// Grid line test pattern: one pixel coordinate in, one RGB color out.
// ----------------------------------------------------------------------------
// Usage:
//   Coordinate channel: column and row travel with coord_valid; a beat is
//   taken on a rising edge with coord_valid high and coord_stall low.
//   Color channel: red, green, blue and on_line travel with color_valid; the
//   receiver takes a beat when it holds color_stall low.
//   Throughput: one pixel per clock, with no gaps, while color_stall is low.
//   Pipeline: a coordinate beat reaches the color beat through one stage
//   for the coordinate * cell count product, three stages of a restoring
//   remainder unit (7 dividend bits each), one stage for the edge compare
//   and color select that also serves as the output register.
//   Stall: each stage holds while the one after it is full and stalled, so
//   bubbles collapse; coord_stall rises only when all five stages are full
//   and the receiver stalls. Nothing is dropped or repeated.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   at a rising edge; write only while no pixel is in flight. Unknown
//   indexes are ignored.
//   Reset: rst (synchronous, active high) empties the pipeline and loads the
//   default settings: 256 x 256 image, 8 x 8 cells, thickness 3277/65536,
//   white fill and black lines.
// ----------------------------------------------------------------------------
module grid_pattern_pixel_generator import gpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // coordinate channel
  input  logic                  coord_valid,
  output logic                  coord_stall,
  input  logic [COORD_W-1:0]    column,
  input  logic [COORD_W-1:0]    row,
  // color channel
  output logic                  color_valid,
  input  logic                  color_stall,
  output logic [CHAN_W-1:0]     red,
  output logic [CHAN_W-1:0]     green,
  output logic [CHAN_W-1:0]     blue,
  output logic                  on_line
);

  localparam int LAST = NUM_STAGES - 1;

  // Settings registers.
  logic [DIM_CFG_W-1:0]  image_width;
  logic [DIM_CFG_W-1:0]  image_height;
  logic [CELL_CFG_W-1:0] cell_columns;
  logic [CELL_CFG_W-1:0] cell_rows;
  logic [THICK_W-1:0]    line_thickness;
  logic [COLOR_W-1:0]    fill_color;
  logic [COLOR_W-1:0]    grid_color;

  // Pipeline control.
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] stage_ready;
  logic [NUM_STAGES-1:0] src_valid;
  logic [NUM_STAGES-1:0] load;

  axis_cfg_t   cfg_x;
  axis_cfg_t   cfg_y;
  logic        near_x;
  logic        near_y;
  logic        line_hit;
  logic [COLOR_W-1:0] color_sel;

  // Decode register writes; drop unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      cell_columns   <= RST_CELL_COLUMNS;
      cell_rows      <= RST_CELL_ROWS;
      line_thickness <= RST_LINE_THICKNESS;
      fill_color     <= RST_FILL_COLOR;
      grid_color     <= RST_GRID_COLOR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[DIM_CFG_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[DIM_CFG_W-1:0];
        REG_CELL_COLUMNS:   cell_columns   <= cfg_data[CELL_CFG_W-1:0];
        REG_CELL_ROWS:      cell_rows      <= cfg_data[CELL_CFG_W-1:0];
        REG_LINE_THICKNESS: line_thickness <= cfg_data[THICK_W-1:0];
        REG_FILL_COLOR:     fill_color     <= cfg_data[COLOR_W-1:0];
        REG_GRID_COLOR:     grid_color     <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes and cell counts before they reach the axis datapaths.
  assign cfg_x = '{d: clamp_div(image_width), cells: clamp_cells(cell_columns),
                   thick: line_thickness};
  assign cfg_y = '{d: clamp_div(image_height), cells: clamp_cells(cell_rows),
                   thick: line_thickness};

  // A stage may load when it is empty or its own contents move on.
  always_comb begin
    stage_ready[LAST] = !stage_valid[LAST] || !color_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  assign src_valid   = {stage_valid[LAST-1:0], coord_valid};
  assign load        = stage_ready & src_valid;
  assign coord_stall = !stage_ready[0];

  // Advance valid bits alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= src_valid[k];
        end
      end
    end
  end

  gpg_axis u_axis_x (
    .clk  (clk),
    .load (load[DIV_STAGES:0]),
    .pos  (column),
    .cfg  (cfg_x),
    .near (near_x)
  );

  gpg_axis u_axis_y (
    .clk  (clk),
    .load (load[DIV_STAGES:0]),
    .pos  (row),
    .cfg  (cfg_y),
    .near (near_y)
  );

  // Pick the color and hold it in the output register.
  assign line_hit  = near_x || near_y;
  assign color_sel = line_hit ? grid_color : fill_color;

  always_ff @(posedge clk) begin
    if (load[LAST]) begin
      red     <= color_sel[23:16];
      green   <= color_sel[15:8];
      blue    <= color_sel[7:0];
      on_line <= line_hit;
    end
  end

  assign color_valid = stage_valid[LAST];

  // The input stalls only with every stage full and the receiver stalled.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    coord_stall |-> (&stage_valid && color_stall))
    else $error("coordinate stall with pipeline not full");

  // An accepted coordinate occupies the first stage next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (coord_valid && !coord_stall) |=> stage_valid[0])
    else $error("accepted beat missing from first stage");

  // A taken result with an empty stage behind it leaves the output empty.
  a_bubble_drains: assert property (@(posedge clk) disable iff (rst)
    (color_valid && !color_stall && !stage_valid[LAST-1]) |=> !color_valid)
    else $error("result repeated after delivery");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (stage_valid == '0))
    else $error("pipeline not empty after reset");

endmodule

>>> sim/grid_pattern_pixel_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_pattern_pixel_generator_tb
// Self-checking bench for the grid pattern pixel generator. Coordinates are
// fed from a backlog queue by a clocked driver. A clocked monitor compares
// every color beat, field by field, with a prediction made when the
// coordinate was first offered. Directed corner settings come first. Random
// settings and coordinates follow, under several idle/stall mixes, and one
// long receiver hold-off lets the pipeline back up into coord_stall.
// ----------------------------------------------------------------------------
module grid_pattern_pixel_generator_tb;
  import gpg_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_PIXELS = 106;
  localparam int RAND_PHASES  = 12;
  localparam int TIMEOUT_NS   = 5_000_000;

  // Index beyond the register list: the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] xpos;
    logic [COORD_W-1:0] ypos;
  } coord_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              on_line;
  } pixel_t;

  // Every input has a known value from time zero.
  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  coord_valid = 1'b0;
  logic                  coord_stall;
  logic [COORD_W-1:0]    column      = '0;
  logic [COORD_W-1:0]    row         = '0;
  logic                  color_valid;
  logic                  color_stall = 1'b0;
  logic [CHAN_W-1:0]     red;
  logic [CHAN_W-1:0]     green;
  logic [CHAN_W-1:0]     blue;
  logic                  on_line;

  // Bench copy of the register file, raw as written (masked to width).
  logic [DIM_CFG_W-1:0]  set_width  = RST_IMAGE_WIDTH;
  logic [DIM_CFG_W-1:0]  set_height = RST_IMAGE_HEIGHT;
  logic [CELL_CFG_W-1:0] set_cols   = RST_CELL_COLUMNS;
  logic [CELL_CFG_W-1:0] set_rows   = RST_CELL_ROWS;
  logic [THICK_W-1:0]    set_thick  = RST_LINE_THICKNESS;
  logic [COLOR_W-1:0]    set_fill   = RST_FILL_COLOR;
  logic [COLOR_W-1:0]    set_grid   = RST_GRID_COLOR;

  coord_t coord_backlog[$];   // coordinates not yet offered
  pixel_t awaited_colors[$];  // predicted colors, oldest first

  int idle_pct  = 0;          // chance in 100 that the driver leaves a gap
  int stall_pct = 0;          // chance in 100 that the monitor stalls
  int hold_left = 0;          // cycles of forced receiver hold-off left
  logic hold_kick = 1'b0;
  int mismatches = 0;

  grid_pattern_pixel_generator u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .column      (column),
    .row         (row),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .on_line     (on_line)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Color prediction
  // --------------------------------------------------------------------------

  // One axis: is the fraction of (pos * cells) / (size - 1), or one minus it,
  // strictly below thickness / 65536? Compare exactly by cross-multiplying.
  function automatic logic axis_near_line(logic [COORD_W-1:0]    pos,
                                          logic [DIM_CFG_W-1:0]  size,
                                          logic [CELL_CFG_W-1:0] cells);
    logic [31:0] span;
    logic [31:0] count;
    logic [31:0] frac;
    logic [31:0] lim;
    // Clamp size into [2, MAX_DIM] and use size - 1 as the divisor.
    if (size < 2) begin
      span = 32'd1;
    end else if (32'(size) > 32'(MAX_DIM)) begin
      span = 32'(MAX_DIM) - 32'd1;
    end else begin
      span = 32'(size) - 32'd1;
    end
    // Zero cells acts as one; saturate at MAX_CELLS.
    if (cells == '0) begin
      count = 32'd1;
    end else if (32'(cells) > 32'(MAX_CELLS)) begin
      count = 32'(MAX_CELLS);
    end else begin
      count = 32'(cells);
    end
    frac = (32'(pos) * count) % span;
    lim  = 32'(set_thick) * span;
    return ((frac << 16) < lim) || (((span - frac) << 16) < lim);
  endfunction

  function automatic pixel_t grid_pixel_color(logic [COORD_W-1:0] xpos,
                                              logic [COORD_W-1:0] ypos);
    pixel_t           pix;
    logic             hit;
    logic [COLOR_W-1:0] shade;
    hit = axis_near_line(xpos, set_width, set_cols) ||
          axis_near_line(ypos, set_height, set_rows);
    shade = hit ? set_grid : set_fill;
    pix.red     = shade[23:16];
    pix.green   = shade[15:8];
    pix.blue    = shade[7:0];
    pix.on_line = hit;
    return pix;
  endfunction

  // --------------------------------------------------------------------------
  // Coordinate driver
  // --------------------------------------------------------------------------
  // Hold the beat while stalled. Otherwise advance to the next backlog entry,
  // or drop valid for a gap. The prediction is queued the moment a coordinate
  // is first offered: valid is never withdrawn, so it will be accepted, and
  // the monitor never depends on the order of the two blocks in a step.
  always @(posedge clk) begin : drive_coords
    coord_t nxt;
    if (rst) begin
      coord_valid <= 1'b0;
    end else if (!coord_valid || !coord_stall) begin
      if (coord_backlog.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        nxt = coord_backlog.pop_front();
        awaited_colors.push_back(grid_pixel_color(nxt.xpos, nxt.ypos));
        coord_valid <= 1'b1;
        column      <= nxt.xpos;
        row         <= nxt.ypos;
      end else begin
        coord_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Color monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_colors
    pixel_t want;
    if (rst) begin
      color_stall <= 1'b0;
    end else begin
      if (color_valid && !color_stall) begin
        if (awaited_colors.size() == 0) begin
          $display("%0t ns: color beat with none expected, got %0h %0h %0h line %0b",
                   $time, red, green, blue, on_line);
          mismatches++;
        end else begin
          want = awaited_colors.pop_front();
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
          check_field("on_line", CHAN_W'(want.on_line), CHAN_W'(on_line));
        end
      end
      color_stall <= (hold_left != 0) || ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the stimulus only has to kick it.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Write one register at a rising edge and mirror it in the bench copy.
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:    set_width  = val[DIM_CFG_W-1:0];
      REG_IMAGE_HEIGHT:   set_height = val[DIM_CFG_W-1:0];
      REG_CELL_COLUMNS:   set_cols   = val[CELL_CFG_W-1:0];
      REG_CELL_ROWS:      set_rows   = val[CELL_CFG_W-1:0];
      REG_LINE_THICKNESS: set_thick  = val[THICK_W-1:0];
      REG_FILL_COLOR:     set_fill   = val[COLOR_W-1:0];
      REG_GRID_COLOR:     set_grid   = val[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] wd, hd, cc, cr, th,
                           fc, gc);
    write_setting(REG_IMAGE_WIDTH, wd);
    write_setting(REG_IMAGE_HEIGHT, hd);
    write_setting(REG_CELL_COLUMNS, cc);
    write_setting(REG_CELL_ROWS, cr);
    write_setting(REG_LINE_THICKNESS, th);
    write_setting(REG_FILL_COLOR, fc);
    write_setting(REG_GRID_COLOR, gc);
  endtask

  task automatic push_coord(input int x, input int y);
    coord_t c;
    c.xpos = COORD_W'(x);
    c.ypos = COORD_W'(y);
    coord_backlog.push_back(c);
  endtask

  // Wait until every coordinate is offered and every color has come back,
  // then let the pipeline settle before the next register write.
  task automatic wait_idle();
    do @(negedge clk);
    while (coord_backlog.size() != 0 || coord_valid || awaited_colors.size() != 0);
    repeat (NUM_STAGES + 3) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_dim();
    case ($urandom_range(3, 0))
      0:       return CFG_DATA_W'($urandom_range(24, 2));
      1:       return CFG_DATA_W'($urandom_range(MAX_DIM, 2));
      2:       return CFG_DATA_W'($urandom_range(8191, 0));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_cells();
    case ($urandom_range(3, 0))
      0:       return CFG_DATA_W'($urandom_range(16, 1));
      1:       return CFG_DATA_W'($urandom_range(MAX_CELLS, 1));
      2:       return CFG_DATA_W'($urandom_range(511, 0));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_thick();
    case ($urandom_range(3, 0))
      0:       return CFG_DATA_W'($urandom_range(2000, 0));
      1:       return CFG_DATA_W'($urandom_range(20000, 3000));
      2:       return CFG_DATA_W'($urandom_range(65535, 0));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Effective image extent on one axis, for coordinates inside the image.
  function automatic int image_extent(logic [DIM_CFG_W-1:0] size);
    if (size < 2) return 2;
    if (32'(size) > 32'(MAX_DIM)) return MAX_DIM;
    return int'(size);
  endfunction

  // Mostly coordinates inside the image, the rest anywhere in the field.
  task automatic queue_random(input int count);
    int x;
    int y;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99, 0) < 75) begin
        x = $urandom_range(image_extent(set_width) - 1, 0);
        y = $urandom_range(image_extent(set_height) - 1, 0);
      end else begin
        x = $urandom_range(4095, 0);
        y = $urandom_range(4095, 0);
      end
      push_coord(x, y);
    end
  endtask

  task automatic set_pace(input int mode);
    case (mode % 4)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 66; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 66; end
      default: begin idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: corners, a pixel just past a cell edge, mid-cell,
    // and coordinates beyond the 256 x 256 image.
    set_pace(0);
    push_coord(0, 0);
    push_coord(16, 16);
    push_coord(32, 40);
    push_coord(255, 255);
    push_coord(300, 17);
    push_coord(4095, 4095);
    wait_idle();

    // Sizes below two and above MAX_DIM, zero and oversize cell counts,
    // full thickness so every pixel is on a line.
    write_all(24'd0, 24'd8191, 24'd0, 24'd511, 24'd65535, 24'h123456, 24'hA5C3F0);
    // Unmapped index must leave everything untouched.
    write_setting(REG_UNMAPPED, 24'hFFFFFF);
    set_pace(3);
    push_coord(0, 100);
    push_coord(1, 5);
    push_coord(4095, 0);
    push_coord(2048, 2048);
    push_coord(17, 4094);
    wait_idle();

    // Largest image and cells, zero thickness: never on a line.
    write_all(24'd4096, 24'd2, 24'd256, 24'd1, 24'd0, 24'h000000, 24'hFFFFFF);
    set_pace(1);
    push_coord(0, 0);
    push_coord(4095, 1);
    push_coord(123, 0);
    push_coord(4095, 4095);
    wait_idle();

    // One past the clamps, minimal thickness: only exact edges are lines.
    write_all(24'd1, 24'd4097, 24'd257, 24'd2, 24'd1, 24'hFFFFFF, 24'h000000);
    set_pace(2);
    push_coord(0, 0);
    push_coord(1, 2048);
    push_coord(2048, 2047);
    push_coord(3000, 4095);
    wait_idle();

    // Random settings and coordinates, cycling through the pacing mixes.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_all(rand_dim(), rand_dim(), rand_cells(), rand_cells(), rand_thick(),
                CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      set_pace(ph);
      queue_random(PHASE_PIXELS);
      wait_idle();

      // Once: hold the receiver off while the driver keeps offering beats,
      // so the pipeline fills and coord_stall rises.
      if (ph == RAND_PHASES / 2) begin
        set_pace(0);
        hold_kick = 1'b1;
        queue_random(60);
        do @(negedge clk);
        while (hold_left == 0);
        hold_kick = 1'b0;
        wait_idle();
      end
    end

    repeat (2 * NUM_STAGES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/gpg_pkg.sv
rtl/gpg_axis.sv
rtl/grid_pattern_pixel_generator.sv
sim/grid_pattern_pixel_generator_tb.sv
